>>> hdl/fifo_block_cache_tag_engine_macros.svh
// Assertion macros shared by the checker of the block cache tag engine.
`ifndef FIFO_BLOCK_CACHE_TAG_ENGINE_MACROS_SVH
`define FIFO_BLOCK_CACHE_TAG_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define FBCTE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tag engine check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define FBCTE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tag engine check failed");

`endif

>>> hdl/fbcte_pkg.sv
// Types and constants of the block cache tag engine.
package fbcte_pkg;

   localparam int OP_W       = 2;
   localparam int BLK_W      = 16;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 4;
   localparam int CNT_W      = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_CACHE_ENABLE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_VALID_BLOCK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LIMIT       = 2'd2;

   localparam logic [BLK_W-1:0] FIRST_VALID_RESET = 16'd8;
   localparam logic [BLK_W-1:0] BLOCK_LIMIT_RESET = 16'hFFFF;

   typedef enum logic [OP_W-1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_HIT          = 3'd0,
      STAT_FILLED       = 3'd1,
      STAT_NOT_CACHED   = 3'd2,
      STAT_OUT_OF_RANGE = 3'd3,
      STAT_CLEARED      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE    = 2'd0,
      S_SCAN    = 2'd1,
      S_RESOLVE = 2'd2
   } state_type;

endpackage

>>> hdl/fbcte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fbcte_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/fifo_block_cache_tag_engine.sv
// Tag search and FIFO replacement engine of a fully associative block cache.
// With caching on, a read or an in-range write compares one slot per cycle until a hit or the
// last slot; a hit ends the scan early. Other requests go straight to resolution without a scan.
// A stalled result holds back the next one; one request is in flight at a time.
// Reset clears sequencer, valid bits, FIFO head and counters and loads register defaults.
module fifo_block_cache_tag_engine #(
   parameter int ENTRIES    = 16,
   parameter int BLOCK_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [fbcte_pkg::OP_W-1:0]         req_operation,
   input  logic [fbcte_pkg::BLK_W-1:0]        req_block_number,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [fbcte_pkg::STATUS_W-1:0]     rsp_status,
   output logic [fbcte_pkg::SLOT_OUT_W-1:0]   rsp_slot,
   output logic [fbcte_pkg::CNT_W-1:0]        rsp_hit_total,
   output logic [fbcte_pkg::CNT_W-1:0]        rsp_miss_total,
   input  logic                               csr_wr_en,
   input  logic [fbcte_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fbcte_pkg::BLK_W-1:0]        csr_wdata
);

   import fbcte_pkg::*;

   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);
   localparam logic [BLK_W-1:0] BLK_MASK =
      (BLOCK_BITS >= BLK_W) ? {BLK_W{1'b1}} : BLK_W'((64'd1 << BLOCK_BITS) - 64'd1);

   state_type              state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [BLK_W-1:0]       blk_ff, blk_in;
   logic                   in_range_ff, in_range_in;
   logic                   found_ff, found_in;
   logic [SLOT_W-1:0]      found_slot_ff, found_slot_in;
   logic [SLOT_W-1:0]      cmp_idx_ff, cmp_idx_in;
   logic [SLOT_W-1:0]      head_ff, head_in;
   logic [ENTRIES-1:0]     valid_ff, valid_in;
   logic [CNT_W-1:0]       hit_ff, hit_in;
   logic [CNT_W-1:0]       miss_ff, miss_in;
   logic                   enable_ff, enable_in;
   logic [BLK_W-1:0]       first_ff, first_in;
   logic [BLK_W-1:0]       limit_ff, limit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]      rsp_slot_ff, rsp_slot_in;

   logic                   req_take;
   logic                   out_free;
   logic                   resolve_go;
   logic                   need_scan;
   logic                   tag_match;
   logic [BLK_W-1:0]       req_blk;
   logic [BLOCK_BITS-1:0]  tag;
   logic [BLOCK_BITS-1:0]  rd_data;
   logic [SLOT_W-1:0]      rd_addr;
   logic                   fill;
   logic                   clear;
   logic                   bump_hit;
   logic                   bump_miss;
   status_type             status;
   logic [SLOT_W-1:0]      slot;

   fbcte_ram #(
      .WIDTH (BLOCK_BITS),
      .DEPTH (ENTRIES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (fill),
      .wr_addr (head_ff),
      .wr_data (tag),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_blk   = req_block_number & BLK_MASK;
   assign tag       = BLOCK_BITS'(blk_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tag_match = valid_ff[cmp_idx_ff] && (rd_data == tag);
   assign need_scan = enable_ff &&
                      ((req_operation == OP_READ) ||
                       ((req_operation == OP_WRITE) && in_range_in));

   // Sequencer outputs.
   always_comb begin
      req_stall  = (state_ff != S_IDLE);
      req_take   = (state_ff == S_IDLE) && req_valid;
      resolve_go = (state_ff == S_RESOLVE) && out_free;
      // The RAM is always one slot ahead of the compare, so slot 0 is read while idle.
      if ((state_ff == S_SCAN) && (cmp_idx_ff != LAST_SLOT)) begin
         rd_addr = cmp_idx_ff + 1'b1;
      end else begin
         rd_addr = '0;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = need_scan ? S_SCAN : S_RESOLVE;
            end
         end
         S_SCAN: begin
            if (tag_match || (cmp_idx_ff == LAST_SLOT)) begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Request capture and tag scan.
   always_comb begin
      in_range_in   = (req_blk >= first_ff) && (req_blk < limit_ff);
      op_in         = op_ff;
      blk_in        = blk_ff;
      found_in      = found_ff;
      found_slot_in = found_slot_ff;
      cmp_idx_in    = cmp_idx_ff;
      if (req_take) begin
         op_in         = req_operation;
         blk_in        = req_blk;
         found_in      = 1'b0;
         found_slot_in = '0;
         cmp_idx_in    = '0;
      end else if (state_ff == S_SCAN) begin
         if (tag_match) begin
            found_in      = 1'b1;
            found_slot_in = cmp_idx_ff;
         end else if (cmp_idx_ff != LAST_SLOT) begin
            cmp_idx_in = cmp_idx_ff + 1'b1;
         end
      end
   end

   // Outcome of the request once the scan is over.
   always_comb begin
      status    = STAT_OUT_OF_RANGE;
      slot      = '0;
      fill      = 1'b0;
      clear     = 1'b0;
      bump_hit  = 1'b0;
      bump_miss = 1'b0;
      case (op_ff)
         OP_READ: begin
            if (found_ff) begin
               status   = STAT_HIT;
               slot     = found_slot_ff;
               bump_hit = 1'b1;
            end else begin
               bump_miss = 1'b1;
               if (!in_range_ff) begin
                  status = STAT_OUT_OF_RANGE;
               end else if (enable_ff) begin
                  status = STAT_FILLED;
                  slot   = head_ff;
                  fill   = 1'b1;
               end else begin
                  status = STAT_NOT_CACHED;
               end
            end
         end
         OP_WRITE: begin
            if (!in_range_ff) begin
               status = STAT_OUT_OF_RANGE;
            end else if (!enable_ff) begin
               status = STAT_NOT_CACHED;
            end else if (found_ff) begin
               status = STAT_HIT;
               slot   = found_slot_ff;
            end else begin
               status = STAT_FILLED;
               slot   = head_ff;
               fill   = 1'b1;
            end
         end
         OP_CLEAR: begin
            status = STAT_CLEARED;
            clear  = 1'b1;
         end
         default: status = STAT_OUT_OF_RANGE;
      endcase
      if (!resolve_go) begin
         fill      = 1'b0;
         clear     = 1'b0;
         bump_hit  = 1'b0;
         bump_miss = 1'b0;
      end
   end

   // Cache state, counters and the result register.
   always_comb begin
      valid_in = valid_ff;
      head_in  = head_ff;
      hit_in   = hit_ff;
      miss_in  = miss_ff;
      if (clear) begin
         valid_in = '0;
         hit_in   = '0;
         miss_in  = '0;
      end
      if (fill) begin
         valid_in[head_ff] = 1'b1;
         head_in = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      end
      if (bump_hit && (hit_ff != {CNT_W{1'b1}})) begin
         hit_in = hit_ff + 1'b1;
      end
      if (bump_miss && (miss_ff != {CNT_W{1'b1}})) begin
         miss_in = miss_ff + 1'b1;
      end

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      if (resolve_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status;
         rsp_slot_in   = slot;
      end
   end

   // Configuration registers.
   always_comb begin
      enable_in = enable_ff;
      first_in  = first_ff;
      limit_in  = limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CACHE_ENABLE:      enable_in = csr_wdata[0];
            CSR_FIRST_VALID_BLOCK: first_in  = csr_wdata;
            CSR_BLOCK_LIMIT:       limit_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         valid_ff     <= '0;
         hit_ff       <= '0;
         miss_ff      <= '0;
         enable_ff    <= 1'b0;
         first_ff     <= FIRST_VALID_RESET;
         limit_ff     <= BLOCK_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         valid_ff     <= valid_in;
         hit_ff       <= hit_in;
         miss_ff      <= miss_in;
         enable_ff    <= enable_in;
         first_ff     <= first_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      found_ff      <= found_in;
      found_slot_ff <= found_slot_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      if (req_take) begin
         in_range_ff <= in_range_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_hit_total  = hit_ff;
   assign rsp_miss_total = miss_ff;

endmodule

>>> hdl/fbcte_chk.sv
// Port-level checker of the block cache tag engine and its bind statement.
`include "fifo_block_cache_tag_engine_macros.svh"

module fbcte_chk (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [fbcte_pkg::STATUS_W-1:0]     rsp_status,
   input logic [fbcte_pkg::SLOT_OUT_W-1:0]   rsp_slot,
   input logic [fbcte_pkg::CNT_W-1:0]        rsp_hit_total,
   input logic [fbcte_pkg::CNT_W-1:0]        rsp_miss_total
);

   import fbcte_pkg::*;

   logic [STATUS_W+SLOT_OUT_W+2*CNT_W-1:0] rsp_payload;
   logic                                   rsp_names_slot;
   logic                                   rsp_counts_zero;

   assign rsp_payload     = {rsp_status, rsp_slot, rsp_hit_total, rsp_miss_total};
   assign rsp_names_slot  = (rsp_status == STAT_HIT) || (rsp_status == STAT_FILLED);
   assign rsp_counts_zero = (rsp_hit_total == '0) && (rsp_miss_total == '0);

   // A stalled result keeps its whole payload.
   `FBCTE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // Only a hit or a fill names a slot.
   `FBCTE_ASSERT_NOW(a_slot_zero, rsp_valid && !rsp_names_slot, rsp_slot == '0)

   // A clear leaves both counters at zero.
   `FBCTE_ASSERT_NOW(a_clear_counts, rsp_valid && (rsp_status == STAT_CLEARED), rsp_counts_zero)

   // A request is taken only once the previous one has left the sequencer.
   `FBCTE_ASSERT_NEXT(a_one_in_flight, req_valid && !req_stall, req_stall)

endmodule

bind fifo_block_cache_tag_engine fbcte_chk u_fbcte_chk (.*);

>>> tb/sv/tb_fifo_block_cache_tag_engine.sv
`timescale 1ns / 100ps
// Self-checking testbench of the FIFO block cache tag engine.
module tb_fifo_block_cache_tag_engine;
   import fbcte_pkg::*;

   localparam int ENTRIES = 16;
   localparam int SETTLE_CYCLES = ENTRIES + 6;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      status_type            status;
      logic [SLOT_OUT_W-1:0] slot;
      logic [CNT_W-1:0]      hits;
      logic [CNT_W-1:0]      misses;
   } lookup_outcome_type;

   // Tracks tags, valid bits, FIFO head and counters, and holds the outcomes still due.
   class lookup_tracker;
      logic [BLK_W-1:0]      tags [ENTRIES];
      bit                    valid [ENTRIES];
      logic [SLOT_OUT_W-1:0] head;
      logic [CNT_W-1:0]      hit_count;
      logic [CNT_W-1:0]      miss_count;
      bit                    enable;
      logic [BLK_W-1:0]      first_block;
      logic [BLK_W-1:0]      limit_block;
      lookup_outcome_type    outstanding [$];
      int                    failures;

      function new();
         foreach (tags[i]) begin
            tags[i] = '0;
            valid[i] = 1'b0;
         end
         head = '0;
         hit_count = '0;
         miss_count = '0;
         enable = 1'b0;
         first_block = FIRST_VALID_RESET;
         limit_block = BLOCK_LIMIT_RESET;
         failures = 0;
      endfunction

      function void set_config(logic [CSR_IDX_W-1:0] idx, logic [BLK_W-1:0] val);
         case (idx)
            CSR_CACHE_ENABLE:      enable = val[0];
            CSR_FIRST_VALID_BLOCK: first_block = val;
            CSR_BLOCK_LIMIT:       limit_block = val;
            default: ;
         endcase
      endfunction

      // The lowest valid slot holding the tag, or -1.
      function int find_tag(logic [BLK_W-1:0] blk);
         for (int i = 0; i < ENTRIES; i++)
            if (valid[i] && tags[i] == blk)
               return i;
         return -1;
      endfunction

      function logic [SLOT_OUT_W-1:0] fill_head(logic [BLK_W-1:0] blk);
         logic [SLOT_OUT_W-1:0] s;
         s = head;
         tags[s] = blk;
         valid[s] = 1'b1;
         head = head + 1'b1;
         return s;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
         lookup_outcome_type o;
         bit in_range;
         int idx;
         in_range = (blk >= first_block) && (blk < limit_block);
         o.status = STAT_OUT_OF_RANGE;
         o.slot = '0;
         case (op)
            OP_READ: begin
               idx = enable ? find_tag(blk) : -1;
               if (idx >= 0) begin
                  if (hit_count != '1)
                     hit_count++;
                  o.status = STAT_HIT;
                  o.slot = idx[SLOT_OUT_W-1:0];
               end else begin
                  if (miss_count != '1)
                     miss_count++;
                  if (!in_range) begin
                     o.status = STAT_OUT_OF_RANGE;
                  end else if (enable) begin
                     o.status = STAT_FILLED;
                     o.slot = fill_head(blk);
                  end else begin
                     o.status = STAT_NOT_CACHED;
                  end
               end
            end
            OP_WRITE: begin
               if (!in_range) begin
                  o.status = STAT_OUT_OF_RANGE;
               end else if (!enable) begin
                  o.status = STAT_NOT_CACHED;
               end else begin
                  idx = find_tag(blk);
                  if (idx >= 0) begin
                     o.status = STAT_HIT;
                     o.slot = idx[SLOT_OUT_W-1:0];
                  end else begin
                     o.status = STAT_FILLED;
                     o.slot = fill_head(blk);
                  end
               end
            end
            OP_CLEAR: begin
               foreach (valid[i])
                  valid[i] = 1'b0;
               hit_count = '0;
               miss_count = '0;
               o.status = STAT_CLEARED;
            end
            default: ;
         endcase
         o.hits = hit_count;
         o.misses = miss_count;
         outstanding.push_back(o);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         failures++;
      endtask

      task check_outcome(logic [STATUS_W-1:0] status, logic [SLOT_OUT_W-1:0] slot,
                         logic [CNT_W-1:0] hits, logic [CNT_W-1:0] misses);
         lookup_outcome_type o;
         if (outstanding.size() == 0) begin
            report("response arrived with no request outstanding");
            return;
         end
         o = outstanding.pop_front();
         if (status !== o.status)
            report($sformatf("status %0d, expected %s", status, o.status.name()));
         if (slot !== o.slot)
            report($sformatf("slot %0d, expected %0d", slot, o.slot));
         if (hits !== o.hits)
            report($sformatf("hit total %0d, expected %0d", hits, o.hits));
         if (misses !== o.misses)
            report($sformatf("miss total %0d, expected %0d", misses, o.misses));
      endtask

      task final_check();
         if (outstanding.size() != 0)
            report($sformatf("%0d responses never arrived", outstanding.size()));
      endtask
   endclass

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [OP_W-1:0]       req_operation = '0;
   logic [BLK_W-1:0]      req_block_number = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [STATUS_W-1:0]   rsp_status;
   logic [SLOT_OUT_W-1:0] rsp_slot;
   logic [CNT_W-1:0]      rsp_hit_total;
   logic [CNT_W-1:0]      rsp_miss_total;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [BLK_W-1:0]      csr_wdata = '0;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   lookup_tracker tracker = new();

   fifo_block_cache_tag_engine #(
      .ENTRIES    (ENTRIES),
      .BLOCK_BITS (BLK_W)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_block_number (req_block_number),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_slot         (rsp_slot),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_miss_total   (rsp_miss_total),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

   // Response side: check every accepted response and stall at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
            tracker.check_outcome(rsp_status, rsp_slot, rsp_hit_total, rsp_miss_total);
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [BLK_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      tracker.set_config(idx, val);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_window(bit en, logic [BLK_W-1:0] first, logic [BLK_W-1:0] limit);
      write_reg(CSR_CACHE_ENABLE, {{(BLK_W-1){1'b0}}, en});
      write_reg(CSR_FIRST_VALID_BLOCK, first);
      write_reg(CSR_BLOCK_LIMIT, limit);
   endtask

   // Hold off new requests until every response is back and the engine has gone quiet.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.outstanding.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_request(logic [OP_W-1:0] op, logic [BLK_W-1:0] blk);
      req_valid <= 1'b1;
      req_operation <= op;
      req_block_number <= blk;
      do @(posedge clock); while (req_stall !== 1'b0);
      tracker.note_request(op, blk);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Mostly reads and writes over a working set a little larger than the cache,
   // so that hits, fills and evictions all occur; the rest is unconstrained noise.
   task automatic run_phase(int count, int base, int idle_pct, int stall_pct);
      logic [OP_W-1:0]  op;
      logic [BLK_W-1:0] blk;
      int pick;
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 20) begin
            op = OP_W'($urandom_range(3));
            blk = BLK_W'($urandom);
         end else begin
            pick = $urandom_range(99);
            op = (pick < 62) ? OP_READ : (pick < 98) ? OP_WRITE : OP_CLEAR;
            blk = BLK_W'(base + $urandom_range(ENTRIES + 7));
         end
         send_request(op, blk);
         if (i % 97 == 96)
            drain();
      end
      drain();
   endtask

   initial begin
      logic [BLK_W-1:0] rnd_first;
      logic [BLK_W-1:0] rnd_limit;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Settings as they come out of reset: caching off.
      send_request(OP_READ, 16'd100);
      send_request(OP_READ, 16'd3);
      send_request(OP_WRITE, 16'd100);
      send_request(OP_WRITE, 16'hFFFF);
      send_request(OP_UNUSED, 16'hFFFF);
      drain();

      set_window(1'b1, 16'd8, 16'hFFFF);
      send_request(OP_READ, 16'd8);
      send_request(OP_READ, 16'd8);
      send_request(OP_WRITE, 16'd8);
      send_request(OP_WRITE, 16'hFFFE);
      send_request(OP_READ, 16'd7);
      send_request(OP_READ, 16'hFFFF);
      send_request(OP_CLEAR, 16'h0000);
      // The head is kept across a clear, so this fill lands past the earlier ones.
      send_request(OP_READ, 16'hFFFE);
      send_request(OP_UNUSED, 16'h0000);
      drain();

      // Empty range: a cached block still hits on a read, but a write is refused.
      set_window(1'b1, 16'd0, 16'd0);
      send_request(OP_READ, 16'hFFFE);
      send_request(OP_READ, 16'h0000);
      send_request(OP_WRITE, 16'hFFFE);
      drain();

      set_window(1'b1, 16'd0, 16'hFFFF);
      send_request(OP_WRITE, 16'h0000);
      send_request(OP_READ, 16'h0000);
      send_request(OP_READ, 16'h5555);
      send_request(OP_WRITE, 16'hAAAA);
      drain();

      set_window(1'b1, 16'd8, 16'hFFFF);
      run_phase(140, 8, 0, 0);
      set_window(1'b1, 16'd0, 16'd40000);
      run_phase(140, 39990, 62, 0);
      set_window(1'b1, 16'd1000, 16'd1012);
      run_phase(140, 995, 0, 62);
      set_window(1'b0, 16'd0, 16'hFFFF);
      run_phase(80, 0, 24, 24);
      rnd_first = BLK_W'($urandom);
      rnd_limit = BLK_W'($urandom);
      set_window(1'b1, rnd_first, rnd_limit);
      run_phase(100, rnd_first, 24, 24);
      set_window(1'b1, 16'hFFF0, 16'hFFFF);
      run_phase(100, 16'hFFF0, 0, 0);

      tracker.final_check();
      if (tracker.failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
